[rtl/client_slot_table_defines.svh]
// ----------------------------------------------------------------------------
// client_slot_table_defines
// Assertion macros used by the slot table checker.
// ----------------------------------------------------------------------------
`ifndef CLIENT_SLOT_TABLE_DEFINES_SVH
`define CLIENT_SLOT_TABLE_DEFINES_SVH

// same-cycle implication, reset masked
`define CST_ASSERT_NOW(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masked
`define CST_ASSERT_NEXT(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/cst_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_pkg
// Shared widths, status codes and control structs of the client slot table.
// ----------------------------------------------------------------------------
package cst_pkg;

	localparam int SLOTS_DEFAULT = 16;

	localparam int MAC_W   = 48;
	localparam int IP_W    = 32;
	localparam int PORT_W  = 16;
	localparam int PID_W   = 22;
	localparam int STAT_W  = 2;
	localparam int SLOT_W  = 4;
	localparam int COUNT_W = 5;
	localparam int COUNT_MAX = 31;

	localparam logic KIND_ADD    = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	localparam logic [STAT_W-1:0] ST_ADDED   = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
	localparam logic [STAT_W-1:0] ST_REMOVED = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOMATCH = 2'd3;

	typedef struct packed {
		logic [MAC_W-1:0]  mac;
		logic [IP_W-1:0]   ip;
		logic [PORT_W-1:0] cport;
		logic [PORT_W-1:0] sport;
		logic [PID_W-1:0]  pid;
	} slot_entry_t;

	typedef struct packed {
		logic load;
		logic rd_en;
		logic wr;
		logic finish;
	} cst_cmd_t;

	typedef struct packed {
		logic chk_vld;
		logic hit;
		logic chk_last;
		logic issue_done;
	} cst_sts_t;

endpackage

[rtl/client_slot_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// client_slot_table
// Fixed table of client connection slots with add and remove requests.
// ----------------------------------------------------------------------------
//  channel   handshake         payload
//  request   start / busy      kind, mac_address, ip_address, client_port,
//                              server_port, process_id
//  result    done (strobe)     status, slot_index, occupied_count
//
//  A beat is taken when start is high and busy low; one result beat follows.
//  The scan reads one slot a cycle from the slot memory through its single
//  registered read port; a hit passes through a write state that commits
//  the slot, a miss ends on the last slot; busy drops as done rises.
//  Reset clears the per-slot valid bits at once; no clearing pass.
//  The result beat lasts one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module client_slot_table
	import cst_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEFAULT
)(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                kind,
	input  logic [MAC_W-1:0]    mac_address,
	input  logic [IP_W-1:0]     ip_address,
	input  logic [PORT_W-1:0]   client_port,
	input  logic [PORT_W-1:0]   server_port,
	input  logic [PID_W-1:0]    process_id,
	output logic                done,
	output logic [STAT_W-1:0]   status,
	output logic [SLOT_W-1:0]   slot_index,
	output logic [COUNT_W-1:0]  occupied_count
);

	cst_cmd_t cmd;
	cst_sts_t sts;

	cst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	cst_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.kind           (kind),
		.mac_address    (mac_address),
		.ip_address     (ip_address),
		.client_port    (client_port),
		.server_port    (server_port),
		.process_id     (process_id),
		.done           (done),
		.status         (status),
		.slot_index     (slot_index),
		.occupied_count (occupied_count)
	);

endmodule

[rtl/cst_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_ctrl
// Sequencer: accepts a request, steps the slot scan, commits a hit, reports.
// ----------------------------------------------------------------------------
module cst_ctrl
	import cst_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  cst_sts_t sts,
	output cst_cmd_t cmd,
	output logic     busy
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_WRITE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       found;
	logic       miss;

	assign found = sts.chk_vld && sts.hit;
	assign miss  = sts.chk_vld && !sts.hit && sts.chk_last;
	assign busy  = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.rd_en = !sts.issue_done && !found;
				if (found) begin
					state_d = S_WRITE;
				end else if (miss) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_WRITE: begin
				cmd.wr     = 1'b1;
				cmd.finish = 1'b1;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[rtl/cst_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_dp
// Slot memory with per-slot valid bits, scan pointer, match logic,
// occupancy counter and result registers.
// ----------------------------------------------------------------------------
module cst_dp
	import cst_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEFAULT
)(
	input  logic                clk,
	input  logic                arst_n,
	input  cst_cmd_t            cmd,
	output cst_sts_t            sts,
	input  logic                kind,
	input  logic [MAC_W-1:0]    mac_address,
	input  logic [IP_W-1:0]     ip_address,
	input  logic [PORT_W-1:0]   client_port,
	input  logic [PORT_W-1:0]   server_port,
	input  logic [PID_W-1:0]    process_id,
	output logic                done,
	output logic [STAT_W-1:0]   status,
	output logic [SLOT_W-1:0]   slot_index,
	output logic [COUNT_W-1:0]  occupied_count
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

	slot_entry_t       mem_q [SLOTS];
	logic [SLOTS-1:0]  valid_q;

	logic              req_kind_q;
	slot_entry_t       req_q;

	logic [IW-1:0]     addr_q;
	logic              issue_done_q;
	slot_entry_t       rd_s1;
	logic              rv_s1;
	logic [IW-1:0]     idx_s1;
	logic              chk_vld_s1;

	logic [CW-1:0]     count_q;
	logic              done_q;
	logic [STAT_W-1:0] status_q;
	logic [SLOT_W-1:0] slot_q;

	slot_entry_t       cur;
	slot_entry_t       wr_entry;
	logic              hit;
	logic              old_occ;
	logic              new_occ;

	assign cur = rv_s1 ? rd_s1 : '0;

	always_comb begin
		if (req_kind_q == KIND_ADD) begin
			hit = (cur.sport == '0) && (cur.cport == '0);
		end else begin
			hit = (cur.sport == req_q.sport) || (cur.pid == req_q.pid);
		end
	end

	assign old_occ  = (cur.sport != '0) || (cur.pid != '0);
	assign wr_entry = (req_kind_q == KIND_ADD) ? req_q : '0;
	assign new_occ  = (req_kind_q == KIND_ADD) &&
		((req_q.sport != '0) || (req_q.pid != '0));

	assign sts.chk_vld    = chk_vld_s1;
	assign sts.hit        = hit;
	assign sts.chk_last   = (idx_s1 == LAST_IDX);
	assign sts.issue_done = issue_done_q;

	// request hold, no reset
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_kind_q <= kind;
			req_q.mac  <= mac_address;
			req_q.ip   <= ip_address;
			req_q.cport <= client_port;
			req_q.sport <= server_port;
			req_q.pid  <= process_id;
		end
	end

	// slot memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem_q[idx_s1] <= wr_entry;
		end
		if (cmd.rd_en) begin
			rd_s1  <= mem_q[addr_q];
			idx_s1 <= addr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			rv_s1        <= 1'b0;
			addr_q       <= '0;
			issue_done_q <= 1'b0;
			chk_vld_s1   <= 1'b0;
			count_q      <= '0;
			done_q       <= 1'b0;
			status_q     <= ST_ADDED;
			slot_q       <= '0;
		end else begin
			chk_vld_s1 <= cmd.rd_en;
			done_q     <= cmd.finish;
			if (cmd.load) begin
				addr_q       <= '0;
				issue_done_q <= 1'b0;
			end else if (cmd.rd_en) begin
				rv_s1 <= valid_q[addr_q];
				if (addr_q == LAST_IDX) begin
					issue_done_q <= 1'b1;
				end else begin
					addr_q <= addr_q + 1'b1;
				end
			end
			if (cmd.wr) begin
				valid_q[idx_s1] <= 1'b1;
				count_q <= count_q + CW'(new_occ) - CW'(old_occ);
			end
			if (cmd.finish) begin
				if (req_kind_q == KIND_ADD) begin
					status_q <= cmd.wr ? ST_ADDED : ST_FULL;
				end else begin
					status_q <= cmd.wr ? ST_REMOVED : ST_NOMATCH;
				end
				slot_q <= cmd.wr ? SLOT_W'(idx_s1) : '0;
			end
		end
	end

	assign done           = done_q;
	assign status         = status_q;
	assign slot_index     = slot_q;
	assign occupied_count = (int'(count_q) > COUNT_MAX) ? COUNT_W'(COUNT_MAX)
		: COUNT_W'(count_q);

endmodule

[rtl/cst_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_checker
// Port-level checks of the client slot table, bound to the top level.
// ----------------------------------------------------------------------------
`include "client_slot_table_defines.svh"

module cst_checker
	import cst_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input logic [STAT_W-1:0]  status,
	input logic [SLOT_W-1:0]  slot_index
);

	`CST_ASSERT_NEXT(a_take_sets_busy, clk, arst_n, start && !busy, busy, "beat taken but busy low")
	`CST_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done, "result strobe longer than one cycle")
	`CST_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy, "result shown while still busy")
	`CST_ASSERT_NOW(a_miss_slot_zero, clk, arst_n, done && (status == ST_FULL || status == ST_NOMATCH), slot_index == '0, "slot index nonzero on a miss")

endmodule

bind client_slot_table cst_checker u_cst_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.status     (status),
	.slot_index (slot_index)
);

[sim/tb_client_slot_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_client_slot_table
// Self-checking bench for the client slot table. A queue of add and remove
// requests feeds a start/busy driver with random idle bursts; a monitor keeps
// a shadow of the slot table, predicts status, slot and occupied count for
// every request beat and checks each done beat against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_client_slot_table;
	import cst_pkg::*;

	localparam int TABLE_SLOTS  = SLOTS_DEFAULT;
	localparam int RANDOM_ITEMS = 1750;
	localparam int BLOCK_ITEMS  = 50;
	localparam int TAIL_ITEMS   = 200;
	localparam int SETTLE_CYCLES = 4 * TABLE_SLOTS;

	typedef struct packed {
		logic        kind;
		slot_entry_t body;
	} request_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [SLOT_W-1:0]  slot;
		logic [COUNT_W-1:0] count;
	} outcome_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               kind = 1'b0;
	logic [MAC_W-1:0]   mac_address = '0;
	logic [IP_W-1:0]    ip_address = '0;
	logic [PORT_W-1:0]  client_port = '0;
	logic [PORT_W-1:0]  server_port = '0;
	logic [PID_W-1:0]   process_id = '0;
	logic               busy;
	logic               done;
	logic [STAT_W-1:0]  status;
	logic [SLOT_W-1:0]  slot_index;
	logic [COUNT_W-1:0] occupied_count;

	request_t    request_queue[$];
	outcome_t    pending_outcomes[$];
	slot_entry_t shadow_slots[TABLE_SLOTS];
	int unsigned issued_cnt = 0;
	int unsigned accepted_cnt = 0;
	int unsigned gap_left = 0;
	int          failures = 0;

	client_slot_table #(
		.SLOTS(TABLE_SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.mac_address(mac_address),
		.ip_address(ip_address),
		.client_port(client_port),
		.server_port(server_port),
		.process_id(process_id),
		.done(done),
		.status(status),
		.slot_index(slot_index),
		.occupied_count(occupied_count)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic outcome_t apply_request(request_t req);
		outcome_t    res;
		bit          found;
		int unsigned used;
		int unsigned n;
		found = 1'b0;
		used = 0;
		n = 0;
		if (req.kind == KIND_ADD) begin
			for (int i = 0; i < TABLE_SLOTS && !found; i++) begin
				if (shadow_slots[i].sport == '0 && shadow_slots[i].cport == '0) begin
					shadow_slots[i] = req.body;
					used = i;
					found = 1'b1;
				end
			end
			res.status = found ? ST_ADDED : ST_FULL;
		end else begin
			for (int i = 0; i < TABLE_SLOTS && !found; i++) begin
				if (shadow_slots[i].sport == req.body.sport ||
				    shadow_slots[i].pid == req.body.pid) begin
					shadow_slots[i] = '0;
					used = i;
					found = 1'b1;
				end
			end
			res.status = found ? ST_REMOVED : ST_NOMATCH;
		end
		foreach (shadow_slots[i])
			if (shadow_slots[i].sport != '0 || shadow_slots[i].pid != '0)
				n++;
		res.slot = SLOT_W'(used);
		res.count = (n > COUNT_MAX) ? COUNT_W'(COUNT_MAX) : COUNT_W'(n);
		return res;
	endfunction

	task automatic queue_item(logic k, logic [MAC_W-1:0] mac, logic [IP_W-1:0] ip,
			logic [PORT_W-1:0] cport, logic [PORT_W-1:0] sport, logic [PID_W-1:0] pid);
		request_t req;
		req.kind = k;
		req.body = '{mac: mac, ip: ip, cport: cport, sport: sport, pid: pid};
		request_queue.push_back(req);
	endtask

	// driver: hold a beat until taken, otherwise idle or present the next request
	always @(negedge clk) begin : drive_proc
		request_t    nxt;
		logic        raise;
		logic [63:0] noise;
		if (arst_n && !(start && accepted_cnt != issued_cnt)) begin
			raise = 1'b0;
			noise = {$urandom(), $urandom()};
			nxt.kind = noise[63];
			nxt.body.mac = noise[MAC_W-1:0];
			nxt.body.ip = $urandom();
			nxt.body.cport = PORT_W'($urandom());
			nxt.body.sport = PORT_W'($urandom());
			nxt.body.pid = PID_W'($urandom());
			if (gap_left != 0) begin
				gap_left--;
			end else if (request_queue.size() != 0) begin
				nxt = request_queue.pop_front();
				raise = 1'b1;
				issued_cnt++;
				if (request_queue.size() > TAIL_ITEMS && $urandom_range(0, 3) == 0)
					gap_left = $urandom_range(1, 4);
			end
			start <= raise;
			kind <= nxt.kind;
			mac_address <= nxt.body.mac;
			ip_address <= nxt.body.ip;
			client_port <= nxt.body.cport;
			server_port <= nxt.body.sport;
			process_id <= nxt.body.pid;
		end
	end

	// monitor: check the result beat first, then predict a newly taken request
	always @(posedge clk) begin : monitor_proc
		outcome_t exp;
		request_t req;
		if (arst_n) begin
			if (done) begin
				if (pending_outcomes.size() == 0) begin
					$error("result beat with no request outstanding");
					failures++;
				end else begin
					exp = pending_outcomes.pop_front();
					if (status !== exp.status) begin
						$error("status expected %0d actual %0d", exp.status, status);
						failures++;
					end
					if (slot_index !== exp.slot) begin
						$error("slot_index expected %0d actual %0d", exp.slot, slot_index);
						failures++;
					end
					if (occupied_count !== exp.count) begin
						$error("occupied_count expected %0d actual %0d",
							exp.count, occupied_count);
						failures++;
					end
				end
			end
			if (start && !busy) begin
				req.kind = kind;
				req.body = '{mac: mac_address, ip: ip_address, cport: client_port,
					sport: server_port, pid: process_id};
				pending_outcomes.push_back(apply_request(req));
				accepted_cnt++;
			end
		end
	end

	initial begin : stimulus_proc
		logic [PORT_W-1:0] sport_pool[8];
		logic [PID_W-1:0]  pid_pool[8];
		logic [63:0]       wide;
		logic              k;
		logic [PORT_W-1:0] cport;
		logic [PORT_W-1:0] sport;
		logic [PID_W-1:0]  pid;
		int unsigned       add_pct;
		foreach (shadow_slots[i])
			shadow_slots[i] = '0;
		sport_pool[0] = '0;
		sport_pool[1] = '1;
		sport_pool[2] = PORT_W'(1);
		pid_pool[0] = '0;
		pid_pool[1] = '1;
		pid_pool[2] = PID_W'(1);
		for (int i = 3; i < 8; i++) begin
			sport_pool[i] = PORT_W'($urandom());
			pid_pool[i] = PID_W'($urandom());
		end

		// empty table: a zero key hits free slot 0, an all-ones key misses
		queue_item(KIND_REMOVE, '0, '0, '0, '0, '0);
		queue_item(KIND_REMOVE, '0, '0, '0, '1, '1);
		queue_item(KIND_ADD, '1, '1, '1, '1, '1);
		// zero ports leave the slot free for the next add
		queue_item(KIND_ADD, '0, '0, '0, '0, '0);
		queue_item(KIND_ADD, 48'h0123_4567_89ab, 32'hc0a8_0001, '0, '0, PID_W'(5));
		queue_item(KIND_ADD, 48'h0a0b_0c0d_0e0f, 32'h0a00_0001, PORT_W'(7), '0, '0);
		// fill the rest, then overflow
		for (int i = 0; i < 15; i++) begin
			wide = {$urandom(), $urandom()};
			queue_item(KIND_ADD, wide[MAC_W-1:0], $urandom(),
				PORT_W'(16'h0200 + i), PORT_W'(16'h0100 + i), PID_W'(i + 2));
		end
		queue_item(KIND_REMOVE, '0, '0, '0, PORT_W'(16'h0105), PID_W'(22'h3ffffe));
		queue_item(KIND_REMOVE, '0, '0, '0, PORT_W'(16'hfffe), PID_W'(9));
		queue_item(KIND_REMOVE, '0, '0, '0, '0, PID_W'(22'h3ffffe));
		queue_item(KIND_REMOVE, '0, '0, '0, '1, PID_W'(22'h3ffffe));

		for (int blk = 0; blk < RANDOM_ITEMS / BLOCK_ITEMS; blk++) begin
			case ($urandom_range(0, 2))
				0: add_pct = 85;
				1: add_pct = 50;
				default: add_pct = 25;
			endcase
			for (int n = 0; n < BLOCK_ITEMS; n++) begin
				k = ($urandom_range(0, 99) < add_pct) ? KIND_ADD : KIND_REMOVE;
				sport = ($urandom_range(0, 99) < 80) ? sport_pool[$urandom_range(0, 7)]
					: PORT_W'($urandom());
				pid = ($urandom_range(0, 99) < 80) ? pid_pool[$urandom_range(0, 7)]
					: PID_W'($urandom());
				cport = ($urandom_range(0, 9) == 0) ? '0 : PORT_W'($urandom());
				if (k == KIND_ADD && $urandom_range(0, 24) == 0) begin
					cport = '0;
					sport = '0;
				end
				wide = {$urandom(), $urandom()};
				queue_item(k, wide[MAC_W-1:0], $urandom(), cport, sport, pid);
			end
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (request_queue.size() != 0 || accepted_cnt != issued_cnt ||
		       pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_outcomes.size() != 0) begin
			$error("%0d results never arrived", pending_outcomes.size());
			failures++;
		end
		if (failures == 0)
			$display("tb_client_slot_table passed");
		else
			$display("tb_client_slot_table failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_client_slot_table failed");
		$finish;
	end

endmodule
